FILE: sv/pfs_pkg.sv
package pfs_pkg;

  localparam int DEFAULT_MAX_LEN = 1024;
  localparam int BORDER_W        = 10;
  localparam int CHAR_W          = 8;
  localparam int IN_DATA_W       = 8;
  localparam int OUT_DATA_W      = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_DONE
  } pfs_state_t;

endpackage

FILE: sv/pfs_ram.sv
module pfs_ram
  import pfs_pkg::*;
#(
  parameter int WIDTH = BORDER_W,
  parameter int DEPTH = DEFAULT_MAX_LEN,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/prefix_function_stream.sv
// Streaming KMP prefix function. Each input transfer carries one byte in
// in_tdata and a start-of-string flag in in_tuser, and each produces exactly
// one output transfer holding the longest proper border length of the prefix
// ending at that byte (overflow in out_tuser when the byte did not fit in the
// MAX_LEN-entry stores and was dropped). From acceptance, an item passes
// through FETCH and CMP, again through both for each fallback step along
// stored border lengths, and then through DONE to the output register;
// each step is one read of the character and border memories followed by
// one compare. The sequencer then returns to IDLE, so a byte is finished
// before the next one is taken. Fallback steps average at most one per byte
// of a string, and the first byte of a string or a dropped byte goes straight
// from acceptance to DONE. A new byte is accepted only while the sequencer is
// idle; a finished result waits in the output register, and the sequencer
// holds its last state while that register is still full.
module prefix_function_stream
  import pfs_pkg::*;
#(
  parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] character
  input  logic                  in_tuser,   // [0] start_string
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] border_length, [15:10] zero
  output logic                  out_tuser   // [0] overflow
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int PW = $clog2(MAX_LEN + 1);

  pfs_state_t state_r, state_nxt;

  logic [PW-1:0]     pos_r, pos_nxt, pos_eff;
  logic [AW-1:0]     j_r, j_nxt;
  logic [AW-1:0]     len_r, len_nxt;
  logic [AW-1:0]     last_border_r, last_border_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BORDER_W-1:0] out_len_r, out_len_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic              wr_en;
  logic [CHAR_W-1:0] text_q;
  logic [AW-1:0]     border_q;
  logic [AW+BORDER_W-1:0] len_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-BORDER_W){1'b0}}, out_len_r};
  assign out_tuser  = out_ovf_r;
  assign len_ext    = {{BORDER_W{1'b0}}, len_r};
  assign pos_eff    = in_tuser ? '0 : pos_r;

  pfs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_text_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_r[AW-1:0]),
    .wr_data (char_r),
    .rd_addr (j_r),
    .rd_data (text_q)
  );

  pfs_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_border_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos_r[AW-1:0]),
    .wr_data (len_r),
    .rd_addr (j_r - AW'(1)),
    .rd_data (border_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r           <= j_nxt;
    len_r         <= len_nxt;
    last_border_r <= last_border_nxt;
    char_r        <= char_nxt;
    ovf_r         <= ovf_nxt;
    out_len_r     <= out_len_nxt;
    out_ovf_r     <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    j_nxt           = j_r;
    len_nxt         = len_r;
    last_border_nxt = last_border_r;
    char_nxt        = char_r;
    ovf_nxt         = ovf_r;
    out_valid_nxt   = out_valid_r;
    out_len_nxt     = out_len_r;
    out_ovf_nxt     = out_ovf_r;
    wr_en           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          char_nxt = in_tdata[CHAR_W-1:0];
          pos_nxt  = pos_eff;
          len_nxt  = '0;
          j_nxt    = last_border_r;
          ovf_nxt  = (pos_eff == PW'(MAX_LEN));
          if (pos_eff == PW'(MAX_LEN) || pos_eff == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (text_q == char_r) begin
          len_nxt   = j_r + AW'(1);
          state_nxt = ST_DONE;
        end else if (j_r == '0) begin
          len_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          j_nxt     = border_q;
          state_nxt = ST_FETCH;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          out_len_nxt   = ovf_r ? '0 : len_ext[BORDER_W-1:0];
          if (!ovf_r) begin
            wr_en           = 1'b1;
            pos_nxt         = pos_r + PW'(1);
            last_border_nxt = len_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
